@@ rtl/tlgs_pkg.sv @@
// Package: request codes, job word, state types and the 5x8 font table
`default_nettype none
package tlgs_pkg;

  localparam int unsigned CELL_COLS   = 7;
  localparam int unsigned DEC_DIGITS  = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  MAX_COL     = 8'd11;
  localparam logic [7:0]  MAX_ROW     = 8'd5;
  localparam logic [7:0]  CMD_SET_X   = 8'h80;
  localparam logic [7:0]  CMD_SET_Y   = 8'h40;
  localparam logic [7:0]  BLANK_BYTE  = 8'h00;
  localparam logic [6:0]  FONT_FIRST  = 7'h20;
  localparam logic [6:0]  BLANK_IDX   = 7'h00;
  localparam logic [6:0]  DIGIT_IDX   = 7'h10;
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    FUNC_CHAR   = 2'd0,
    FUNC_DEC    = 2'd1,
    FUNC_CURSOR = 2'd2
  } func_e;

  typedef enum logic {
    JOB_GLYPH = 1'b0,
    JOB_CMD   = 1'b1
  } job_kind_e;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_CONV = 2'd1,
    F_PUSH = 2'd2
  } front_state_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_RUN  = 1'b1
  } back_state_e;

  typedef logic [6:0]      font_idx_t;
  typedef logic [4:0][7:0] glyph_cols_t;

  typedef struct packed {
    job_kind_e            kind;
    logic [2:0]           cells;
    font_idx_t [4:0]      glyph;
    logic [7:0]           cmd_x;
    logic [7:0]           cmd_y;
  } job_t;

  // first column of the glyph in element 4
  function automatic glyph_cols_t font_cols(input font_idx_t idx);
    glyph_cols_t c;
    case (idx)
      7'h00: c = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      7'h01: c = {8'h00, 8'h00, 8'h5f, 8'h00, 8'h00};
      7'h02: c = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
      7'h03: c = {8'h14, 8'h7f, 8'h14, 8'h7f, 8'h14};
      7'h04: c = {8'h24, 8'h2a, 8'h7f, 8'h2a, 8'h12};
      7'h05: c = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
      7'h06: c = {8'h36, 8'h49, 8'h55, 8'h22, 8'h50};
      7'h07: c = {8'h00, 8'h05, 8'h03, 8'h00, 8'h00};
      7'h08: c = {8'h00, 8'h1c, 8'h22, 8'h41, 8'h00};
      7'h09: c = {8'h00, 8'h41, 8'h22, 8'h1c, 8'h00};
      7'h0a: c = {8'h14, 8'h08, 8'h3e, 8'h08, 8'h14};
      7'h0b: c = {8'h08, 8'h08, 8'h3e, 8'h08, 8'h08};
      7'h0c: c = {8'h00, 8'h50, 8'h30, 8'h00, 8'h00};
      7'h0d: c = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      7'h0e: c = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      7'h0f: c = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
      7'h10: c = {8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e};
      7'h11: c = {8'h00, 8'h42, 8'h7f, 8'h40, 8'h00};
      7'h12: c = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      7'h13: c = {8'h21, 8'h41, 8'h45, 8'h4b, 8'h31};
      7'h14: c = {8'h18, 8'h14, 8'h12, 8'h7f, 8'h10};
      7'h15: c = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      7'h16: c = {8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30};
      7'h17: c = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      7'h18: c = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      7'h19: c = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1e};
      7'h1a: c = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      7'h1b: c = {8'h00, 8'h56, 8'h36, 8'h00, 8'h00};
      7'h1c: c = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
      7'h1d: c = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};
      7'h1e: c = {8'h00, 8'h41, 8'h22, 8'h14, 8'h08};
      7'h1f: c = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
      7'h20: c = {8'h32, 8'h49, 8'h79, 8'h41, 8'h3e};
      7'h21: c = {8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e};
      7'h22: c = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h36};
      7'h23: c = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h22};
      7'h24: c = {8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c};
      7'h25: c = {8'h7f, 8'h49, 8'h49, 8'h49, 8'h41};
      7'h26: c = {8'h7f, 8'h09, 8'h09, 8'h09, 8'h01};
      7'h27: c = {8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a};
      7'h28: c = {8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f};
      7'h29: c = {8'h00, 8'h41, 8'h7f, 8'h41, 8'h00};
      7'h2a: c = {8'h20, 8'h40, 8'h41, 8'h3f, 8'h01};
      7'h2b: c = {8'h7f, 8'h08, 8'h14, 8'h22, 8'h41};
      7'h2c: c = {8'h7f, 8'h40, 8'h40, 8'h40, 8'h40};
      7'h2d: c = {8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f};
      7'h2e: c = {8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f};
      7'h2f: c = {8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e};
      7'h30: c = {8'h7f, 8'h09, 8'h09, 8'h09, 8'h06};
      7'h31: c = {8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e};
      7'h32: c = {8'h7f, 8'h09, 8'h19, 8'h29, 8'h46};
      7'h33: c = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      7'h34: c = {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
      7'h35: c = {8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f};
      7'h36: c = {8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f};
      7'h37: c = {8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f};
      7'h38: c = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      7'h39: c = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      7'h3a: c = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      7'h3b: c = {8'h00, 8'h7f, 8'h41, 8'h41, 8'h00};
      7'h3c: c = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      7'h3d: c = {8'h00, 8'h41, 8'h41, 8'h7f, 8'h00};
      7'h3e: c = {8'h04, 8'h02, 8'h01, 8'h02, 8'h04};
      7'h3f: c = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
      7'h40: c = {8'h00, 8'h01, 8'h02, 8'h04, 8'h00};
      7'h41: c = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
      7'h42: c = {8'h7f, 8'h48, 8'h44, 8'h44, 8'h38};
      7'h43: c = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
      7'h44: c = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7f};
      7'h45: c = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      7'h46: c = {8'h08, 8'h7e, 8'h09, 8'h01, 8'h02};
      7'h47: c = {8'h0c, 8'h52, 8'h52, 8'h52, 8'h3e};
      7'h48: c = {8'h7f, 8'h08, 8'h04, 8'h04, 8'h78};
      7'h49: c = {8'h00, 8'h44, 8'h7d, 8'h40, 8'h00};
      7'h4a: c = {8'h20, 8'h40, 8'h44, 8'h3d, 8'h00};
      7'h4b: c = {8'h7f, 8'h10, 8'h28, 8'h44, 8'h00};
      7'h4c: c = {8'h00, 8'h41, 8'h7f, 8'h40, 8'h00};
      7'h4d: c = {8'h7c, 8'h04, 8'h18, 8'h04, 8'h78};
      7'h4e: c = {8'h7c, 8'h08, 8'h04, 8'h04, 8'h78};
      7'h4f: c = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      7'h50: c = {8'h7c, 8'h14, 8'h14, 8'h14, 8'h08};
      7'h51: c = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7c};
      7'h52: c = {8'h7c, 8'h08, 8'h04, 8'h04, 8'h08};
      7'h53: c = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
      7'h54: c = {8'h04, 8'h3f, 8'h44, 8'h40, 8'h20};
      7'h55: c = {8'h3c, 8'h40, 8'h40, 8'h20, 8'h7c};
      7'h56: c = {8'h1c, 8'h20, 8'h40, 8'h20, 8'h1c};
      7'h57: c = {8'h3c, 8'h40, 8'h30, 8'h40, 8'h3c};
      7'h58: c = {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
      7'h59: c = {8'h0c, 8'h50, 8'h50, 8'h50, 8'h3c};
      7'h5a: c = {8'h44, 8'h64, 8'h54, 8'h4c, 8'h44};
      7'h5b: c = {8'h00, 8'h08, 8'h36, 8'h41, 8'h00};
      7'h5c: c = {8'h00, 8'h00, 8'h7f, 8'h00, 8'h00};
      7'h5d: c = {8'h00, 8'h41, 8'h36, 8'h08, 8'h00};
      7'h5e: c = {8'h10, 8'h08, 8'h08, 8'h10, 8'h08};
      7'h5f: c = {8'h1f, 8'h24, 8'h7c, 8'h24, 8'h1f};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tlgs_if.sv @@
// Interfaces: request channel and LCD byte channel
`default_nettype none
interface tlgs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] value;
  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;

  modport source (output valid, func, value, cursor_col, cursor_row, input ready);
  modport sink   (input valid, func, value, cursor_col, cursor_row, output ready);
endinterface

interface tlgs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lcd_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, lcd_byte, is_data, last, input ready);
  modport sink   (input valid, lcd_byte, is_data, last, output ready);
endinterface
`default_nettype wire

@@ rtl/tlgs_front.sv @@
// Front end: takes requests, converts numbers to digits, builds job words
`default_nettype none
module tlgs_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  tlgs_in_if.sink           req_i,
  output tlgs_pkg::job_t    job_o,
  output logic              job_valid_o,
  input  wire logic         job_ready_i
);
  import tlgs_pkg::*;

  front_state_e state_q, state_d;
  job_t         job_q, job_d;
  logic [15:0]  val_q, val_d;
  logic [2:0]   step_q, step_d;
  logic         dec_q, dec_d;

  logic [31:0]  prod;
  logic [12:0]  quo;
  logic [15:0]  quo10;
  logic [15:0]  rem;
  logic [7:0]   code;
  logic         lead;

  assign prod  = 32'(val_q) * DIV10_MUL;
  assign quo   = prod[DIV10_SHIFT +: 13];
  assign quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign rem   = val_q - quo10;
  assign code  = req_i.value[7:0];

  assign req_i.ready = (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);

  // leading zeros of a number become blanks, the ones digit always stays
  always_comb begin
    job_o = job_q;
    lead  = dec_q;
    for (int i = 0; i < DEC_DIGITS - 1; i++) begin
      if (job_q.glyph[i] != DIGIT_IDX) lead = 1'b0;
      if (lead) job_o.glyph[i] = BLANK_IDX;
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    val_d   = val_q;
    step_d  = step_q;
    dec_d   = dec_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          job_d = '0;
          dec_d = 1'b0;
          case (req_i.func)
            FUNC_CHAR: begin
              job_d.kind  = JOB_GLYPH;
              job_d.cells = 3'd1;
              if (!code[7] && code[6:5] != 2'b00) job_d.glyph[0] = code[6:0] - FONT_FIRST;
              state_d = F_PUSH;
            end
            FUNC_DEC: begin
              job_d.kind  = JOB_GLYPH;
              job_d.cells = 3'(DEC_DIGITS);
              dec_d   = 1'b1;
              val_d   = req_i.value;
              step_d  = '0;
              state_d = F_CONV;
            end
            FUNC_CURSOR: begin
              if (req_i.cursor_col <= MAX_COL && req_i.cursor_row <= MAX_ROW) begin
                job_d.kind  = JOB_CMD;
                job_d.cmd_x = CMD_SET_X | 8'(req_i.cursor_col * 8'd7);
                job_d.cmd_y = CMD_SET_Y | req_i.cursor_row;
                state_d = F_PUSH;
              end
            end
            default: state_d = F_IDLE;
          endcase
        end
      end
      F_CONV: begin
        job_d.glyph[3'(DEC_DIGITS - 1) - step_q] = DIGIT_IDX + 7'(rem[3:0]);
        val_d  = {3'b000, quo};
        step_d = step_q + 3'd1;
        if (step_q == 3'(DEC_DIGITS - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    val_q <= val_d;
    dec_q <= dec_d;
  end

endmodule
`default_nettype wire

@@ rtl/tlgs_fifo.sv @@
// Job queue between front and back end
`default_nettype none
module tlgs_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tlgs_pkg::job_t  push_data_i,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  output tlgs_pkg::job_t       pop_data_o,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i
);
  import tlgs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

@@ rtl/tlgs_back.sv @@
// Back end: walks a job cell by cell and column by column into LCD bytes
`default_nettype none
module tlgs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tlgs_pkg::job_t  job_i,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  tlgs_out_if.source           byte_o
);
  import tlgs_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [2:0]  cell_q, cell_d;
  logic [2:0]  col_q, col_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_data_q, out_data_d;
  logic        out_last_q, out_last_d;

  glyph_cols_t cols;
  logic [7:0]  glyph_byte;
  logic        slot_free;
  logic        cell_end, run_end;

  assign cols      = font_cols(job_q.glyph[cell_q]);
  assign slot_free = !out_valid_q || byte_o.ready;
  assign cell_end  = (col_q == 3'(CELL_COLS - 1));
  assign run_end   = (job_q.kind == JOB_CMD) ? (col_q == 3'd1)
                                             : (cell_end && cell_q == job_q.cells - 3'd1);

  assign job_ready_o     = (state_q == B_IDLE);
  assign byte_o.valid    = out_valid_q;
  assign byte_o.lcd_byte = out_byte_q;
  assign byte_o.is_data  = out_data_q;
  assign byte_o.last     = out_last_q;

  always_comb begin
    case (col_q)
      3'd1:    glyph_byte = cols[4];
      3'd2:    glyph_byte = cols[3];
      3'd3:    glyph_byte = cols[2];
      3'd4:    glyph_byte = cols[1];
      3'd5:    glyph_byte = cols[0];
      default: glyph_byte = BLANK_BYTE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    cell_d      = cell_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !byte_o.ready;
    out_byte_d  = out_byte_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_d   = job_i;
          cell_d  = '0;
          col_d   = '0;
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_last_d  = run_end;
          if (job_q.kind == JOB_CMD) begin
            out_byte_d = (col_q == 3'd0) ? job_q.cmd_x : job_q.cmd_y;
            out_data_d = 1'b0;
          end else begin
            out_byte_d = glyph_byte;
            out_data_d = 1'b1;
          end
          if (cell_end) begin
            col_d  = '0;
            cell_d = cell_q + 3'd1;
          end else begin
            col_d = col_q + 3'd1;
          end
          if (run_end) state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cell_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cell_q      <= cell_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_byte_q <= out_byte_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

endmodule
`default_nettype wire

@@ rtl/text_to_lcd_glyph_stream_unit.sv @@
// Top level: request front end, job queue and byte generating back end
//
//   port     dir   words                                   handshake
//   req_i    in    func, value, cursor_col, cursor_row     valid/ready
//   byte_o   out   lcd_byte, is_data, last                 valid/ready
//
// Back end: one byte per cycle while byte_o is not stalled, after loading
// each job in B_IDLE: character 7, number 35, cursor 2 bytes; out-of-range
// cursor and unused func codes give none. Front end: number conversion
// runs one digit a cycle through one 16x16 multiplier, and overlaps the back
// end via the queue. Reset is asynchronous and clears all control state;
// no clearing pass. A stalled byte_o holds its word; the front keeps taking
// requests until the queue is full and its own job word waits to be pushed.
`default_nettype none
module text_to_lcd_glyph_stream_unit #(
  parameter int unsigned QueueDepth = tlgs_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tlgs_in_if.sink     req_i,
  tlgs_out_if.source  byte_o
);
  import tlgs_pkg::*;

  job_t push_job, pop_job;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;

  tlgs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  tlgs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  tlgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .byte_o      (byte_o)
  );

endmodule
`default_nettype wire

@@ rtl/tlgs_checker.sv @@
// Port checker for the glyph stream unit and its bind
`default_nettype none
module tlgs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] lcd_byte_i,
  input wire logic       is_data_i,
  input wire logic       last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(lcd_byte_i) && $stable(last_i))
    else $error("byte word dropped or changed while stalled");

  a_cmd_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_data_i && !last_i |-> lcd_byte_i[7] && lcd_byte_i[6:0] <= 7'd77)
    else $error("bad column command");

  a_cmd_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_data_i && last_i |-> lcd_byte_i[7:3] == 5'b01000 && lcd_byte_i[2:0] <= 3'd5)
    else $error("bad row command");

  a_data_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_data_i |-> !lcd_byte_i[7] && (!last_i || lcd_byte_i == 8'h00))
    else $error("bad data byte");

endmodule

bind text_to_lcd_glyph_stream_unit tlgs_checker u_tlgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .lcd_byte_i  (byte_o.lcd_byte),
  .is_data_i   (byte_o.is_data),
  .last_i      (byte_o.last)
);
`default_nettype wire
